@@ sv/sbu_pkg.sv @@
// Shared constants and inter-module types for the segment bit unpacker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sbu_pkg;

    // Fixed field widths of the stream and the decoded pixel.
    localparam int BYTE_BITS = 8;
    localparam int PIX_W     = 8;
    localparam int SEGW_W    = 4;
    localparam int CNT8_W    = $clog2(BYTE_BITS + 1);

    // Defaults for the header field widths.
    localparam int COUNT_BITS_DEF = 8;
    localparam int WIDTH_BITS_DEF = 3;

    // Segment phase codes; the spare code behaves like the count phase.
    localparam logic [1:0] PH_COUNT  = 2'd0;
    localparam logic [1:0] PH_WIDTH  = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;

    // Bit offered by the byte shifter, or the close of a finished byte.
    typedef struct packed {
        logic bit_valid;
        logic bit_data;
        logic close_valid;
        logic stream_end;
    } sbu_bit_t;

    // Consumption strobes back to the byte shifter.
    typedef struct packed {
        logic bit_take;
        logic close_take;
    } sbu_take_t;

    // Pixel push or byte close toward the output stage.
    typedef struct packed {
        logic              push;
        logic              close;
        logic [PIX_W-1:0]  pixel;
        logic [SEGW_W-1:0] width;
    } sbu_push_t;

    // Readiness of the output stage.
    typedef struct packed {
        logic push_ready;
        logic close_ready;
    } sbu_out_rdy_t;

endpackage

`default_nettype wire

@@ sv/segment_bit_unpacker.sv @@
// Segment bit unpacker: decodes a segment-coded gray-image stream, one bit
// per cycle unless stalled, into zero-extended pixels. Uses sbu_pkg,
// sbu_byte_shifter, sbu_field_decoder and sbu_out_stage.
//
// The block takes one compressed byte per input transfer and reads its bits
// most significant first, one bit per clock cycle unless stalled. Each
// segment is a COUNT_BITS-wide pixel count (stored minus one) and a
// WIDTH_BITS-wide pixel width (stored minus one), followed by that many
// pixels of that width; a field may straddle byte boundaries. Every pixel
// leaves as one output transfer carrying the value, the segment width and
// tlast, which is set on the final pixel produced by the input byte. A byte
// that finishes no pixel produces no transfer. Setting s_axis_tlast marks
// the final byte of an image: once that byte is decoded, its pad bits and
// any segment cut off by it are dropped and the decoder starts the next
// image afresh. With the output not stalled a byte is first loaded, then
// the bit-serial field decoder takes its bits one at a time, and then the
// byte is closed and its last pixel marked. A stalled output holds the
// decoder only while the output register is still full and a pixel is
// waiting in the holding slot at the moment another pixel finishes or the
// byte closes.
`default_nettype none

module segment_bit_unpacker
    import sbu_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream: one compressed byte per transfer.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    input  wire logic        s_axis_tlast,   // stream_end
    // Output stream: one decoded pixel per transfer.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] pixel_value, [11:8] segment_width, rest 0
    output logic             m_axis_tlast    // last_of_byte
);

    sbu_bit_t          bit_bus;
    sbu_take_t         take_bus;
    sbu_push_t         push_bus;
    sbu_out_rdy_t      rdy_bus;
    logic [PIX_W-1:0]  pixel;
    logic [SEGW_W-1:0] width;

    // Serializes each accepted byte into single bits.
    sbu_byte_shifter u_shift (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_byte  (s_axis_tdata),
        .s_end   (s_axis_tlast),
        .bit_out (bit_bus),
        .take    (take_bus)
    );

    // Parses count, width and pixel fields bit by bit.
    sbu_field_decoder #(
        .COUNT_BITS (COUNT_BITS),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .bit_in  (bit_bus),
        .take    (take_bus),
        .push    (push_bus),
        .out_rdy (rdy_bus)
    );

    // Holds the newest pixel until it is known whether it ends the byte.
    sbu_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push_bus),
        .out_rdy (rdy_bus),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_pixel (pixel),
        .m_width (width),
        .m_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, width, pixel};

endmodule

`default_nettype wire

@@ sv/sbu_byte_shifter.sv @@
// Input byte register that hands out one stream bit per cycle when taken,
// MSB first, followed by a close marker for the byte. Depends on sbu_pkg.
`default_nettype none

module sbu_byte_shifter
    import sbu_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [BYTE_BITS-1:0] s_byte,
    input  wire logic                 s_end,
    output sbu_bit_t                  bit_out,
    input  wire sbu_take_t            take
);

    logic [BYTE_BITS-1:0] byte_reg, byte_next;
    logic [CNT8_W-1:0]    cnt_reg, cnt_next;
    logic                 close_reg, close_next;
    logic                 end_reg, end_next;

    assign s_ready = (cnt_reg == '0) && !close_reg;

    assign bit_out.bit_valid   = (cnt_reg != '0);
    assign bit_out.bit_data    = byte_reg[BYTE_BITS-1];
    assign bit_out.close_valid = close_reg;
    assign bit_out.stream_end  = end_reg;

    always_comb begin
        byte_next  = byte_reg;
        cnt_next   = cnt_reg;
        close_next = close_reg;
        end_next   = end_reg;
        if (s_valid && s_ready) begin
            byte_next = s_byte;
            cnt_next  = CNT8_W'(BYTE_BITS);
            end_next  = s_end;
        end else if (take.bit_take) begin
            byte_next = {byte_reg[BYTE_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT8_W'(1);
            if (cnt_reg == CNT8_W'(1)) begin
                close_next = 1'b1;
            end
        end else if (take.close_take) begin
            close_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
        if (!aresetn) begin
            cnt_reg   <= '0;
            close_reg <= 1'b0;
        end else begin
            cnt_reg   <= cnt_next;
            close_reg <= close_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/sbu_field_decoder.sv @@
// Bit-serial segment parser: accumulates count, width and pixel fields one
// bit per unstalled cycle, pushing each finished pixel. Depends on sbu_pkg.
`default_nettype none

module sbu_field_decoder
    import sbu_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire sbu_bit_t     bit_in,
    output sbu_take_t         take,
    output sbu_push_t         push,
    input  wire sbu_out_rdy_t out_rdy
);

    localparam int REM_W = COUNT_BITS + 1;

    logic [1:0]            phase_reg, phase_next;
    logic [PIX_W-1:0]      field_reg, field_next;
    logic [CNT8_W-1:0]     nbits_reg, nbits_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SEGW_W-1:0]     width_reg, width_next;
    logic [REM_W-1:0]      remain_reg, remain_next;

    logic [PIX_W-1:0]  field_shift;
    logic [CNT8_W-1:0] nbits_inc;
    logic              pix_done;

    assign field_shift = {field_reg[PIX_W-2:0], bit_in.bit_data};
    assign nbits_inc   = nbits_reg + CNT8_W'(1);
    assign pix_done    = (phase_reg == PH_PIXELS) && (nbits_inc == CNT8_W'(width_reg));

    assign take.bit_take   = bit_in.bit_valid && !(pix_done && !out_rdy.push_ready);
    assign take.close_take = bit_in.close_valid && out_rdy.close_ready;

    assign push.push  = bit_in.bit_valid && pix_done && out_rdy.push_ready;
    assign push.close = bit_in.close_valid;
    assign push.pixel = field_shift;
    assign push.width = width_reg;

    always_comb begin
        phase_next  = phase_reg;
        field_next  = field_reg;
        nbits_next  = nbits_reg;
        count_next  = count_reg;
        width_next  = width_reg;
        remain_next = remain_reg;
        if (take.bit_take) begin
            field_next = field_shift;
            nbits_next = nbits_inc;
            case (phase_reg)
                PH_WIDTH: begin
                    if (nbits_inc == CNT8_W'(WIDTH_BITS)) begin
                        width_next  = SEGW_W'(field_shift[WIDTH_BITS-1:0]) + SEGW_W'(1);
                        remain_next = REM_W'(count_reg) + REM_W'(1);
                        phase_next  = PH_PIXELS;
                        field_next  = '0;
                        nbits_next  = '0;
                    end
                end
                PH_PIXELS: begin
                    if (pix_done) begin
                        remain_next = remain_reg - REM_W'(1);
                        if (remain_reg == REM_W'(1)) begin
                            phase_next = PH_COUNT;
                        end
                        field_next = '0;
                        nbits_next = '0;
                    end
                end
                default: begin
                    if (nbits_inc == CNT8_W'(COUNT_BITS)) begin
                        count_next = field_shift[COUNT_BITS-1:0];
                        phase_next = PH_WIDTH;
                        field_next = '0;
                        nbits_next = '0;
                    end
                end
            endcase
        end else if (take.close_take && bit_in.stream_end) begin
            // End of image: pad bits and any cut-off segment are dropped.
            phase_next  = PH_COUNT;
            field_next  = '0;
            nbits_next  = '0;
            count_next  = '0;
            width_next  = '0;
            remain_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_COUNT;
            field_reg  <= '0;
            nbits_reg  <= '0;
            count_reg  <= '0;
            width_reg  <= '0;
            remain_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            field_reg  <= field_next;
            nbits_reg  <= nbits_next;
            count_reg  <= count_next;
            width_reg  <= width_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/sbu_out_stage.sv @@
// One-pixel holding slot plus the output register. The slot lets the last
// pixel of a byte be marked once the byte closes. Depends on sbu_pkg.
`default_nettype none

module sbu_out_stage
    import sbu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sbu_push_t         push,
    output sbu_out_rdy_t           out_rdy,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PIX_W-1:0]       m_pixel,
    output logic [SEGW_W-1:0]      m_width,
    output logic                   m_last
);

    logic              pend_valid_reg, pend_valid_next;
    logic [PIX_W-1:0]  pend_pixel_reg, pend_pixel_next;
    logic [SEGW_W-1:0] pend_width_reg, pend_width_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_pixel_reg, out_pixel_next;
    logic [SEGW_W-1:0] out_width_reg, out_width_next;
    logic              out_last_reg, out_last_next;
    logic              out_free;

    assign out_free            = !out_valid_reg || m_ready;
    assign out_rdy.push_ready  = !pend_valid_reg || out_free;
    assign out_rdy.close_ready = !pend_valid_reg || out_free;

    assign m_valid = out_valid_reg;
    assign m_pixel = out_pixel_reg;
    assign m_width = out_width_reg;
    assign m_last  = out_last_reg;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_pixel_next = pend_pixel_reg;
        pend_width_next = pend_width_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_pixel_next  = out_pixel_reg;
        out_width_next  = out_width_reg;
        out_last_next   = out_last_reg;
        if (push.push && out_rdy.push_ready) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_pixel_next = pend_pixel_reg;
                out_width_next = pend_width_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_pixel_next = push.pixel;
            pend_width_next = push.width;
        end else if (push.close && out_rdy.close_ready && pend_valid_reg) begin
            out_valid_next  = 1'b1;
            out_pixel_next  = pend_pixel_reg;
            out_width_next  = pend_width_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        pend_pixel_reg <= pend_pixel_next;
        pend_width_reg <= pend_width_next;
        out_pixel_reg  <= out_pixel_next;
        out_width_reg  <= out_width_next;
        out_last_reg   <= out_last_next;
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/sbu_checker.sv @@
// Port-level checks for segment_bit_unpacker and the bind that attaches
// them. Depends on the top-level port list only.
`default_nettype none

module sbu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    // Segment width is always between one and eight and padding is zero.
    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[11:8] != 4'd0) && (m_axis_tdata[11:8] <= 4'd8)
                          && (m_axis_tdata[15:12] == 4'd0))
        else $error("segment width out of range");

    // The pixel value fits in the segment width.
    a_pixel_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tdata[7:0] >> m_axis_tdata[11:8]) == 8'd0))
        else $error("pixel value wider than its segment");

    // A byte just taken keeps the input closed at the start of its decoding.
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input reopened before byte decoded");

endmodule

bind segment_bit_unpacker sbu_checker u_sbu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
